@@ hw/rtl/pmlr_pkg.sv @@
// ----------------------------------------------------------------------------
// pmlr_pkg
// Shared widths, register indexes and stage types of the looped MAC unit.
// ----------------------------------------------------------------------------
package pmlr_pkg;

  localparam int OPERAND_W  = 32;
  localparam int RESULT_W   = 32;
  localparam int COUNT_W    = 10;
  localparam int ADDR_W     = 32;
  localparam int SHIFT_W    = 6;
  localparam int STEP_W     = 11;
  localparam int EXT_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_STEP    = 3'd5;

  localparam logic        CMD_TICK  = 1'b0;
  localparam logic        CMD_START = 1'b1;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_WAIT,
    KIND_CALC
  } pmlr_kind_t;

  typedef struct packed {
    pmlr_kind_t kind;
    logic       zero_addr;
    logic       finished;
  } pmlr_ctl_t;

endpackage

@@ hw/rtl/pmlr_if.sv @@
// ----------------------------------------------------------------------------
// pmlr_if
// Valid/ready channels of the looped MAC unit: input, result, configuration.
// ----------------------------------------------------------------------------
interface pmlr_in_if import pmlr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [OPERAND_W-1:0] operand_a;
  logic signed [OPERAND_W-1:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

interface pmlr_out_if import pmlr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result;
  logic                       result_written;
  logic                       finished;

  modport source (output valid, result, result_written, finished, input ready);
  modport sink (input valid, result, result_written, finished, output ready);
endinterface

interface pmlr_cfg_if import pmlr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/pipelined_mac_with_loop_reset.sv @@
// ----------------------------------------------------------------------------
// pipelined_mac_with_loop_reset
// Signed multiply-accumulate unit driven by a two-level loop address
// generator, with a start delay and a result latency pipe.
//
// Usage: in_ch carries one beat per command. A start beat clears the loop
// counters, the done flag and the latency pipe, latches the period and loads
// the start delay. A tick beat either counts the delay down or steps the
// address generator and accumulates operand_a * operand_b, or subtracts it
// in subtract mode (restarting the accumulator when the generated address
// is zero). Every input beat yields exactly one out_ch beat carrying the
// pipe end, a written flag and the done flag. cfg_ch writes one register
// per beat and is always ready; write it only while no beat is in flight.
// Path: an accepted beat passes the input stage and the result register to out_ch.
// Throughput: one beat per cycle unless out_ch stalls; the multiplier is
// registered before the 64-bit accumulate; the loop counters update at accept.
// Reset: rst_n clears all but prod_r and the out_ch data; address_step resets to 1.
// Stall: while out_ch is held, the result register holds and one more beat
// is taken into the input stage if it is empty, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module pipelined_mac_with_loop_reset import pmlr_pkg::*; #(
  parameter int LATENCY    = 3,
  parameter int DATA_WIDTH = 32,
  parameter int ACC_WIDTH  = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  pmlr_in_if.sink         in_ch,
  pmlr_out_if.source      out_ch,
  pmlr_cfg_if.sink        cfg_ch
);

  // configuration registers
  logic                     sub_mode_r;
  logic [COUNT_W-1:0]       iter_count_r;
  logic [COUNT_W-1:0]       period_r;
  logic [COUNT_W-1:0]       start_delay_r;
  logic [SHIFT_W-1:0]       shift_r;
  logic signed [STEP_W-1:0] step_r;

  // loop state
  logic [COUNT_W-1:0] delay_left_r, delay_left_nxt;
  logic [COUNT_W-1:0] inner_r, inner_nxt;
  logic [COUNT_W-1:0] outer_r, outer_nxt;
  logic [COUNT_W-1:0] duty_r, duty_nxt;
  logic [COUNT_W-1:0] lat_period_r, lat_period_nxt;
  logic [ADDR_W-1:0]  next_addr_r, next_addr_nxt;
  logic [ADDR_W-1:0]  held_addr_r, held_addr_nxt;
  logic               done_r, done_nxt;

  // input stage
  logic                        s1_valid_r;
  pmlr_ctl_t                   s1_ctl_r, s1_ctl_nxt;
  logic signed [ACC_WIDTH-1:0] prod_r;

  logic signed [DATA_WIDTH-1:0]   op_a, op_b;
  logic signed [2*DATA_WIDTH-1:0] prod_full;
  logic signed [EXT_W-1:0]        prod_ext;

  // result stage
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt, acc_base;
  logic signed [EXT_W-1:0]     acc_ext, acc_shifted;
  logic [RESULT_W-1:0]         calc_val;
  logic [RESULT_W-1:0]         pipe_r [LATENCY];
  logic [RESULT_W-1:0]         pipe_nxt [LATENCY];
  logic                        out_valid_r;
  logic [RESULT_W-1:0]         out_result_r, out_result_nxt;
  logic                        out_written_r, out_written_nxt;
  logic                        out_finished_r;

  logic in_fire, out_free, s2_fire;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s2_fire      = s1_valid_r && out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result         = out_result_r;
  assign out_ch.result_written = out_written_r;
  assign out_ch.finished       = out_finished_r;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_mode_r    <= 1'b0;
      iter_count_r  <= '0;
      period_r      <= '0;
      start_delay_r <= '0;
      shift_r       <= '0;
      step_r        <= STEP_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_SUBTRACT_MODE:   sub_mode_r    <= cfg_ch.data[0];
        CFG_ITERATION_COUNT: iter_count_r  <= cfg_ch.data[COUNT_W-1:0];
        CFG_PERIOD:          period_r      <= cfg_ch.data[COUNT_W-1:0];
        CFG_START_DELAY:     start_delay_r <= cfg_ch.data[COUNT_W-1:0];
        CFG_RESULT_SHIFT:    shift_r       <= cfg_ch.data[SHIFT_W-1:0];
        CFG_ADDRESS_STEP:    step_r        <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // loop address generator and command decode
  always_comb begin
    delay_left_nxt = delay_left_r;
    inner_nxt      = inner_r;
    outer_nxt      = outer_r;
    duty_nxt       = duty_r;
    lat_period_nxt = lat_period_r;
    next_addr_nxt  = next_addr_r;
    held_addr_nxt  = held_addr_r;
    done_nxt       = done_r;
    s1_ctl_nxt.kind = KIND_WAIT;

    if (in_ch.command == CMD_START) begin
      s1_ctl_nxt.kind = KIND_START;
      delay_left_nxt  = start_delay_r;
      inner_nxt       = '0;
      outer_nxt       = '0;
      duty_nxt        = '0;
      next_addr_nxt   = '0;
      lat_period_nxt  = period_r;
      done_nxt        = 1'b0;
    end else if (delay_left_r != '0) begin
      delay_left_nxt = delay_left_r - 1'b1;
    end else begin
      s1_ctl_nxt.kind = KIND_CALC;
      if (outer_r < iter_count_r) begin
        if (inner_nxt < period_r) begin
          inner_nxt = inner_nxt + 1'b1;
          if (duty_nxt < lat_period_r) begin
            held_addr_nxt = next_addr_nxt;
            duty_nxt      = duty_nxt + 1'b1;
            next_addr_nxt = next_addr_nxt + ADDR_W'(step_r);
          end
        end
        if (inner_nxt == period_r) begin
          inner_nxt     = '0;
          duty_nxt      = '0;
          outer_nxt     = outer_nxt + 1'b1;
          next_addr_nxt = next_addr_nxt - ADDR_W'(lat_period_r);
        end
      end
      if (outer_nxt == iter_count_r) begin
        outer_nxt = '0;
        done_nxt  = 1'b1;
      end
    end

    s1_ctl_nxt.zero_addr = (held_addr_nxt == '0);
    s1_ctl_nxt.finished  = done_nxt;
  end

  assign op_a      = in_ch.operand_a[DATA_WIDTH-1:0];
  assign op_b      = in_ch.operand_b[DATA_WIDTH-1:0];
  assign prod_full = op_a * op_b;
  assign prod_ext  = EXT_W'(prod_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_left_r <= '0;
      inner_r      <= '0;
      outer_r      <= '0;
      duty_r       <= '0;
      lat_period_r <= '0;
      next_addr_r  <= '0;
      held_addr_r  <= '0;
      done_r       <= 1'b0;
      s1_valid_r   <= 1'b0;
      s1_ctl_r     <= '{kind: KIND_WAIT, zero_addr: 1'b0, finished: 1'b0};
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (in_fire) begin
        delay_left_r <= delay_left_nxt;
        inner_r      <= inner_nxt;
        outer_r      <= outer_nxt;
        duty_r       <= duty_nxt;
        lat_period_r <= lat_period_nxt;
        next_addr_r  <= next_addr_nxt;
        held_addr_r  <= held_addr_nxt;
        done_r       <= done_nxt;
        s1_ctl_r     <= s1_ctl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r <= prod_ext[ACC_WIDTH-1:0];
    end
  end

  // accumulate, scale and latency pipe
  always_comb begin
    acc_base    = s1_ctl_r.zero_addr ? '0 : acc_r;
    acc_nxt     = sub_mode_r ? (acc_base - prod_r) : (acc_base + prod_r);
    acc_ext     = EXT_W'(acc_nxt);
    acc_shifted = acc_ext >>> shift_r;
    calc_val    = RESULT_W'(signed'(acc_shifted[DATA_WIDTH-1:0]));

    pipe_nxt        = pipe_r;
    out_result_nxt  = '0;
    out_written_nxt = 1'b0;
    unique case (s1_ctl_r.kind)
      KIND_START: begin
        for (int i = 0; i < LATENCY; i++) begin
          pipe_nxt[i] = '0;
        end
      end
      KIND_WAIT: ;
      KIND_CALC: begin
        for (int i = LATENCY - 1; i > 0; i--) begin
          pipe_nxt[i] = pipe_r[i-1];
        end
        pipe_nxt[0]     = calc_val;
        out_result_nxt  = pipe_nxt[LATENCY-1];
        out_written_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LATENCY; i++) begin
        pipe_r[i] <= '0;
      end
    end else begin
      if (s2_fire) begin
        out_valid_r <= 1'b1;
        pipe_r      <= pipe_nxt;
        if (s1_ctl_r.kind == KIND_CALC) begin
          acc_r <= acc_nxt;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_result_r   <= out_result_nxt;
      out_written_r  <= out_written_nxt;
      out_finished_r <= s1_ctl_r.finished;
    end
  end

endmodule

@@ hw/rtl/pmlr_checker.sv @@
// ----------------------------------------------------------------------------
// pmlr_checker
// Port-level assertions for the looped MAC unit, bound to its top level.
// ----------------------------------------------------------------------------
module pmlr_checker import pmlr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [RESULT_W-1:0] out_result,
  input logic                out_result_written,
  input logic                out_finished
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result)
      && $stable(out_result_written) && $stable(out_finished))
    else $error("stalled result beat changed");

  // an unwritten beat carries zero
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_written |-> out_result == '0)
    else $error("unwritten result is not zero");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a beat taken with the result register empty reaches the output via the input stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result beat missing after accept");

endmodule

bind pipelined_mac_with_loop_reset pmlr_checker u_pmlr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_result         (out_ch.result),
  .out_result_written (out_ch.result_written),
  .out_finished       (out_ch.finished)
);
